// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the IIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/iir_pkg.sv =====
// Shared types and constants of the transposed direct form II IIR filter.
`default_nettype none

package iir_pkg;

  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int DELAY_BITS = 40;
  localparam int NUM_COEFS  = 5;
  localparam int STAGE_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_B0_B1 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_B2_B3 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_B4    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEN_A1_A2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEN_A3_A4 = 3'd4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_bank_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_Y_RND,
    ST_A_MUL,
    ST_A_ACC
  } state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_BX,
    MUL_AY
  } mul_op_t;

  typedef struct packed {
    logic               load;
    mul_op_t            mul_op;
    logic [STAGE_W-1:0] coef_k;
    logic               acc_y;
    logic               rnd;
    logic               acc_st;
    logic               wr_st;
    logic [STAGE_W-1:0] stage;
    logic               last;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iir_ctrl.sv =====
// Sequencer of the IIR filter: steps the shared MAC through one sample.
`default_nettype none

module iir_ctrl #(
  parameter int ORDER = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            stall,
  output logic                 in_ready,
  output iir_pkg::dp_cmd_t     cmd
);
  import iir_pkg::*;

  state_t             state, state_next;
  logic [STAGE_W-1:0] k, k_next;
  logic               last;

  assign last = (k == STAGE_W'(ORDER));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      ST_IDLE: begin
        k_next = '0;
        if (in_valid) state_next = ST_Y_MUL;
      end
      ST_Y_MUL: begin
        k_next     = STAGE_W'(1);
        state_next = ST_Y_ACC;
      end
      ST_Y_ACC: state_next = ST_Y_RND;
      ST_Y_RND: begin
        if (!stall) state_next = ST_A_MUL;
      end
      ST_A_MUL: state_next = ST_A_ACC;
      ST_A_ACC: begin
        k_next     = k + STAGE_W'(1);
        state_next = last ? ST_IDLE : ST_A_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.stage = k;
    cmd.last  = last;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_Y_MUL: begin
        cmd.mul_op = MUL_BX;
        cmd.coef_k = k;
      end
      ST_Y_ACC: begin
        cmd.acc_y  = 1'b1;
        cmd.mul_op = MUL_BX;
        cmd.coef_k = k;
      end
      ST_Y_RND: cmd.rnd = !stall;
      ST_A_MUL: begin
        cmd.mul_op = MUL_AY;
        cmd.coef_k = k;
        cmd.acc_st = 1'b1;
      end
      ST_A_ACC: begin
        cmd.wr_st = 1'b1;
        if (!last) begin
          // next stage's b_k * x overlaps the write-back
          cmd.mul_op = MUL_BX;
          cmd.coef_k = k + STAGE_W'(1);
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iir_dpath.sv =====
// Datapath of the IIR filter: shared multiplier, accumulator, delay terms.
`default_nettype none

module iir_dpath #(
  parameter int ORDER       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire iir_pkg::dp_cmd_t         cmd,
  input  wire logic [SAMPLE_BITS-1:0]   sample,
  input  wire logic                     restart,
  input  wire iir_pkg::coef_bank_t      num_coef,
  input  wire iir_pkg::coef_bank_t      den_coef,
  output logic [SAMPLE_BITS-1:0]        y_val,
  output logic                          y_clip
);
  import iir_pkg::*;

  localparam int PW    = COEF_W + SAMPLE_BITS;
  localparam int BW    = (PW > DELAY_BITS) ? PW : DELAY_BITS;
  localparam int AW    = BW + 2;
  localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

  localparam logic signed [AW-1:0] Y_MAX = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] Y_MIN = AW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [AW-1:0] S_MAX = AW'((64'sd1 <<< (DELAY_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] S_MIN = AW'(-(64'sd1 <<< (DELAY_BITS - 1)));
  localparam logic signed [AW-1:0] HALF  = AW'(64'sd1 <<< (COEF_FRAC - 1));

  logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, opnd;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          acc;
  logic signed [DELAY_BITS-1:0]  delay [0:ORDER-1];
  coef_t                         coef;
  logic signed [AW-1:0]          y_full, st_sum, st_add;
  logic signed [DELAY_BITS-1:0]  st_sat;
  logic [IDX_W-1:0]              rd_idx, wr_idx;
  logic [STAGE_W-1:0]            stage_m1;

  assign stage_m1 = cmd.stage - STAGE_W'(1);
  assign rd_idx   = cmd.stage[IDX_W-1:0];
  assign wr_idx   = stage_m1[IDX_W-1:0];

  assign coef = (cmd.mul_op == MUL_AY) ? den_coef[cmd.coef_k] : num_coef[cmd.coef_k];
  assign opnd = (cmd.mul_op == MUL_AY) ? y_reg : x_reg;

  // round half up, floor shift, saturate to sample width
  assign y_full = (acc + HALF) >>> COEF_FRAC;
  always_comb begin
    if (y_full > Y_MAX) begin
      y_val  = Y_MAX[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_val  = Y_MIN[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else begin
      y_val  = y_full[SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end
  end

  // s_(k-1) = b_k*x + s_k - a_k*y, clamped to delay width
  assign st_sum = acc - AW'(prod);
  always_comb begin
    if (st_sum > S_MAX)      st_sat = S_MAX[DELAY_BITS-1:0];
    else if (st_sum < S_MIN) st_sat = S_MIN[DELAY_BITS-1:0];
    else                     st_sat = st_sum[DELAY_BITS-1:0];
  end

  // last stage has no following delay term
  assign st_add = cmd.last ? '0 : AW'(delay[rd_idx]);

  always_ff @(posedge clk) begin
    if (cmd.load) x_reg <= sample;
    if (cmd.mul_op != MUL_NONE) prod <= coef * opnd;
    if (cmd.acc_y)       acc <= AW'(prod) + AW'(delay[0]);
    else if (cmd.acc_st) acc <= AW'(prod) + st_add;
    if (cmd.rnd) y_reg <= y_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) delay[i] <= '0;
    end else if (cmd.load && restart) begin
      for (int i = 0; i < ORDER; i++) delay[i] <= '0;
    end else if (cmd.wr_st) begin
      delay[wr_idx] <= st_sat;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iir_filter_transposed_df2_unit.sv =====
// Top level of the transposed direct form II IIR filter with config registers.
//
// Usage:
//  - Input stream s_*: one word per sample. s_tdata holds sample_in (signed,
//    SAMPLE_BITS wide, zero padded to whole bytes); s_tuser holds restart,
//    which clears all delay terms before the sample is filtered.
//  - Output stream m_*: one word per input word. m_tdata holds sample_out
//    (signed, saturated); m_tuser holds clipped, set when saturation hit.
//  - Config port: cfg_we writes cfg_data to register cfg_addr (0 b0/b1,
//    1 b2/b3, 2 b4, 3 a1/a2, 4 a3/a4, Q2.14 halves). Other indexes ignored.
//    Write only while the filter is idle.
//  - Timing: one shared 16 x SAMPLE_BITS multiplier does every product.
//    The result y is registered in the rounding step, then the delay terms
//    are updated stage by stage, and the next word is taken once the delay
//    update for the last stage is written.
//  - A finished word waits in the output register; the filter already takes
//    the next sample and only holds before its rounding step if the
//    previous word has still not been taken.
//  - Reset: delay terms clear, b0 = 1.0, all other coefficients zero.
`default_nettype none

module iir_filter_transposed_df2_unit #(
  parameter int ORDER       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // slave side
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [SB-1:0] sample_in
  input  wire logic                                  s_tuser,  // [0] restart
  // master side
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]     m_tdata,  // [SB-1:0] sample_out
  output logic                                       m_tuser,  // [0] clipped
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [iir_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire logic [iir_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import iir_pkg::*;

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [CFG_DATA_W-1:0]   num_b0_b1, num_b2_b3, den_a1_a2, den_a3_a4;
  logic [COEF_W-1:0]       num_b4;
  coef_bank_t              num_coef, den_coef;
  dp_cmd_t                 cmd;
  logic                    stall;
  logic [SAMPLE_BITS-1:0]  y_val, out_sample;
  logic                    y_clip, out_clip;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_b0_b1 <= CFG_DATA_W'(16384);
      num_b2_b3 <= '0;
      num_b4    <= '0;
      den_a1_a2 <= '0;
      den_a3_a4 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_B0_B1: num_b0_b1 <= cfg_data;
        REG_NUM_B2_B3: num_b2_b3 <= cfg_data;
        REG_NUM_B4:    num_b4    <= cfg_data[COEF_W-1:0];
        REG_DEN_A1_A2: den_a1_a2 <= cfg_data;
        REG_DEN_A3_A4: den_a3_a4 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign num_coef = {num_b4, num_b2_b3, num_b0_b1};
  // a0 slot is never used; a1..a4 above it
  assign den_coef = {den_a3_a4, den_a1_a2, coef_t'(0)};

  // previous word still pending and not taken this cycle
  assign stall = m_tvalid && !m_tready;

  iir_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stall    (stall),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  iir_dpath #(
    .ORDER       (ORDER),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sample   (s_tdata[SAMPLE_BITS-1:0]),
    .restart  (s_tuser),
    .num_coef (num_coef),
    .den_coef (den_coef),
    .y_val    (y_val),
    .y_clip   (y_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.rnd) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      out_sample <= y_val;
      out_clip   <= y_clip;
    end
  end

  assign m_tdata = DATA_W'(out_sample);
  assign m_tuser = out_clip;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.rnd && m_tvalid && !m_tready, "pending word overwritten")
  `ASSERT_CLK(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "accept while busy")
  `ASSERT_CLK(a_idle_after_last, clk, rst, cmd.wr_st && cmd.last |=> s_tready, "no return to idle")
  `ASSERT_NEVER(a_one_acc_op, clk, rst, cmd.acc_y && cmd.acc_st, "two accumulator ops at once")

endmodule

`default_nettype wire
